>>> sv/dpec_pkg.sv
package dpec_pkg;

  localparam int NORM_BITS = 28;

  // Per-item context that travels down the pipeline
  typedef struct packed {
    logic               deg;
    logic               ovl;
    logic               dxneg;
    logic               dyneg;
    logic               nxneg;
    logic               nyneg;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic [32:0]        ux;
    logic [32:0]        uy;
    logic [31:0]        rsum;
    logic [31:0]        msum;
    logic [30:0]        m2;
    logic [65:0]        sqx;
    logic [65:0]        sqy;
    logic [63:0]        rsq;
    logic [63:0]        d2;
    logic [31:0]        sep;
    logic [31:0]        gap;
    logic [64:0]        gux;
    logic [64:0]        guy;
    logic signed [33:0] q1x;
    logic signed [33:0] q1y;
    logic signed [33:0] q2x;
    logic signed [33:0] q2y;
    logic [32:0]        nx;
    logic [32:0]        ny;
    logic [65:0]        nsqx;
    logic [65:0]        nsqy;
    logic [67:0]        len2;
    logic [33:0]        len;
    logic [28:0]        w2;
    logic signed [29:0] nqx;
    logic signed [29:0] nqy;
    logic signed [61:0] pa1x;
    logic signed [61:0] pa1y;
    logic signed [61:0] pa2x;
    logic signed [61:0] pa2y;
    logic signed [61:0] pb1x;
    logic signed [61:0] pb1y;
    logic signed [61:0] pb2x;
    logic signed [61:0] pb2y;
    logic signed [33:0] a1;
    logic signed [33:0] a2;
    logic signed [33:0] b1;
    logic signed [33:0] b2;
    logic signed [34:0] d21;
    logic signed [34:0] d12;
    logic signed [65:0] e1;
    logic signed [65:0] e2;
    logic signed [36:0] c1;
    logic signed [36:0] c2;
    logic signed [63:0] t1x;
    logic signed [63:0] t1y;
    logic signed [63:0] t2x;
    logic signed [63:0] t2y;
    logic signed [66:0] n1x;
    logic signed [66:0] n1y;
    logic signed [66:0] n2x;
    logic signed [66:0] n2y;
  } ctx_t;

  typedef struct packed {
    logic               collided;
    logic               degenerate;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
    if (x > 70'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -70'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

>>> sv/dpec_delay.sv
module dpec_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [DEPTH-1:0] vsr;
  logic [W-1:0]     dsr [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vsr <= '0;
    end else if (en) begin
      vsr <= {vsr[DEPTH-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsr[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        dsr[i] <= dsr[i-1];
      end
    end
  end

  assign vout = vsr[DEPTH-1];
  assign dout = dsr[DEPTH-1];

endmodule

>>> sv/dpec_sqrt.sv
module dpec_sqrt #(
  parameter int RW = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RW-1:0]     rad,
  output logic [RW/2-1:0]   root
);

  localparam int SW = RW / 2;
  localparam int MW = SW + 2;

  logic [MW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [RW-1:0] rad_q  [SW];

  // One result bit per stage, restoring digit-by-digit square root
  for (genvar g = 0; g < SW; g++) begin : g_stage
    logic [MW-1:0] rem_i;
    logic [SW-1:0] root_i;
    logic [RW-1:0] rad_i;
    logic [MW+1:0] trial;
    logic [MW+1:0] test;
    logic          ge;

    if (g == 0) begin : g_head
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_body
      assign rem_i  = rem_q[g-1];
      assign root_i = root_q[g-1];
      assign rad_i  = rad_q[g-1];
    end

    always_comb begin
      trial = {rem_i, rad_i[RW-1-2*g -: 2]};
      test  = (MW+2)'({root_i, 2'b01});
      ge    = (trial >= test);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g]  <= ge ? MW'(trial - test) : MW'(trial);
        root_q[g] <= {root_i[SW-2:0], ge};
        rad_q[g]  <= rad_i;
      end
    end
  end

  assign root = root_q[SW-1];

endmodule

>>> sv/dpec_div.sv
module dpec_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [QW];
  logic [NW-1:0] num_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  // One quotient bit per stage; the quotient is known to fit QW bits
  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [NW-1:0] num_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic [DW:0]   trial;
    logic          ge;

    if (g == 0) begin : g_head
      assign rem_i = DW'(num >> QW);
      assign num_i = num;
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_body
      assign rem_i = rem_q[g-1];
      assign num_i = num_q[g-1];
      assign den_i = den_q[g-1];
      assign quo_i = quo_q[g-1];
    end

    always_comb begin
      trial = {rem_i, num_i[QW-1-g]};
      ge    = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= ge ? DW'(trial - {1'b0, den_i}) : DW'(trial);
        num_q[g] <= num_i;
        den_q[g] <= den_i;
        quo_q[g] <= {quo_i[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

>>> sv/disc_pair_elastic_collision.sv
// Elastic collision response for one pair of discs, Q16.16 fields.
// Input channel: in_valid / in_stall with one port per disc field. A request
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the collided and degenerate
// flags and the eight corrected positions and velocities.
// Throughput: one pair per cycle while the output is not stalled. Pipeline:
// 145 register stages, set by the two 32- and 34-stage square roots and the
// 31- and 29-stage dividers, plus 19 arithmetic stages around them.
// The output register is the last stage. While out_valid is high and
// out_stall is high the whole pipeline holds and in_stall is raised; no
// request is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
// No configuration and no state between pairs.
module disc_pair_elastic_collision (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic [30:0]        first_radius,
  input  logic [30:0]        first_mass,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic [30:0]        second_radius,
  input  logic [30:0]        second_mass,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               collided,
  output logic               degenerate,
  output logic signed [31:0] new_first_pos_x,
  output logic signed [31:0] new_first_pos_y,
  output logic signed [31:0] new_first_vel_x,
  output logic signed [31:0] new_first_vel_y,
  output logic signed [31:0] new_second_pos_x,
  output logic signed [31:0] new_second_pos_y,
  output logic signed [31:0] new_second_vel_x,
  output logic signed [31:0] new_second_vel_y
);

  import dpec_pkg::*;

  localparam int CW = $bits(ctx_t);

  logic        en;
  logic [18:1] vld;
  logic [18:1] vld_next;
  ctx_t        c    [1:18];
  ctx_t        cn   [1:18];
  res_t        res;
  res_t        res_next;

  ctx_t        xa;
  ctx_t        xb;
  ctx_t        xc;
  ctx_t        xd;
  logic        xav;
  logic        xbv;
  logic        xcv;
  logic        xdv;
  logic [31:0] dist_r;
  logic [30:0] offx;
  logic [30:0] offy;
  logic [33:0] len_r;
  logic [28:0] nmx;
  logic [28:0] nmy;
  logic [28:0] w2q;

  logic [32:0]        dx;
  logic [32:0]        dy;
  logic [66:0]        d2w;
  logic signed [33:0] soffx;
  logic signed [33:0] soffy;
  logic signed [34:0] nrx;
  logic signed [34:0] nry;
  logic [32:0]        bigv;
  logic [32:0]        nxv;
  logic [32:0]        nyv;
  logic signed [62:0] sa1;
  logic signed [62:0] sa2;
  logic signed [62:0] sb1;
  logic signed [62:0] sb2;
  logic [28:0]        w1;
  logic signed [67:0] f1x;
  logic signed [67:0] f1y;
  logic signed [67:0] f2x;
  logic signed [67:0] f2y;
  logic               ok;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Distance between the centres
  dpec_sqrt #(.RW(64)) u_sqrt_dist (
    .clk(clk), .en(en), .rad(c[3].d2), .root(dist_r)
  );
  dpec_delay #(.W(CW), .DEPTH(32)) u_dly_a (
    .clk(clk), .rst(rst), .en(en), .vin(vld[3]), .din(c[3]), .vout(xav), .dout(xa)
  );

  // Half-overlap push per axis
  dpec_div #(.NW(65), .DW(33), .QW(31)) u_div_offx (
    .clk(clk), .en(en), .num(c[5].gux), .den({c[5].sep, 1'b0}), .quo(offx)
  );
  dpec_div #(.NW(65), .DW(33), .QW(31)) u_div_offy (
    .clk(clk), .en(en), .num(c[5].guy), .den({c[5].sep, 1'b0}), .quo(offy)
  );
  dpec_delay #(.W(CW), .DEPTH(31)) u_dly_b (
    .clk(clk), .rst(rst), .en(en), .vin(vld[5]), .din(c[5]), .vout(xbv), .dout(xb)
  );

  // Length of the normalized normal
  dpec_sqrt #(.RW(68)) u_sqrt_len (
    .clk(clk), .en(en), .rad(c[10].len2), .root(len_r)
  );
  dpec_delay #(.W(CW), .DEPTH(34)) u_dly_c (
    .clk(clk), .rst(rst), .en(en), .vin(vld[10]), .din(c[10]), .vout(xcv), .dout(xc)
  );

  // Unit normal in Q28 and mass weight
  dpec_div #(.NW(61), .DW(34), .QW(29)) u_div_nqx (
    .clk(clk), .en(en), .num({c[11].nx, 28'd0}), .den(c[11].len), .quo(nmx)
  );
  dpec_div #(.NW(61), .DW(34), .QW(29)) u_div_nqy (
    .clk(clk), .en(en), .num({c[11].ny, 28'd0}), .den(c[11].len), .quo(nmy)
  );
  dpec_div #(.NW(59), .DW(32), .QW(29)) u_div_w2 (
    .clk(clk), .en(en), .num({c[11].m2, 28'd0}), .den(c[11].msum), .quo(w2q)
  );
  dpec_delay #(.W(CW), .DEPTH(29)) u_dly_d (
    .clk(clk), .rst(rst), .en(en), .vin(vld[11]), .din(c[11]), .vout(xdv), .dout(xd)
  );

  always_comb begin
    vld_next[1] = in_valid;
    for (int k = 2; k <= 18; k++) begin
      vld_next[k] = vld[k-1];
    end
    vld_next[4]  = xav;
    vld_next[6]  = xbv;
    vld_next[11] = xcv;
    vld_next[12] = xdv;

    // Differences, sums, degenerate test
    dx = {first_pos_x[31], first_pos_x} - {second_pos_x[31], second_pos_x};
    dy = {first_pos_y[31], first_pos_y} - {second_pos_y[31], second_pos_y};
    cn[1]       = '0;
    cn[1].p1x   = first_pos_x;
    cn[1].p1y   = first_pos_y;
    cn[1].v1x   = first_vel_x;
    cn[1].v1y   = first_vel_y;
    cn[1].p2x   = second_pos_x;
    cn[1].p2y   = second_pos_y;
    cn[1].v2x   = second_vel_x;
    cn[1].v2y   = second_vel_y;
    cn[1].dxneg = dx[32];
    cn[1].dyneg = dy[32];
    cn[1].ux    = dx[32] ? (33'd0 - dx) : dx;
    cn[1].uy    = dy[32] ? (33'd0 - dy) : dy;
    cn[1].rsum  = {1'b0, first_radius} + {1'b0, second_radius};
    cn[1].msum  = {1'b0, first_mass} + {1'b0, second_mass};
    cn[1].m2    = second_mass;
    cn[1].deg   = ((dx == 33'd0) && (dy == 33'd0)) || (cn[1].msum == 32'd0);

    cn[2]     = c[1];
    cn[2].sqx = c[1].ux * c[1].ux;
    cn[2].sqy = c[1].uy * c[1].uy;
    cn[2].rsq = c[1].rsum * c[1].rsum;

    // Touching counts as overlap
    d2w       = {1'b0, c[2].sqx} + {1'b0, c[2].sqy};
    cn[3]     = c[2];
    cn[3].ovl = (d2w <= {3'b0, c[2].rsq});
    cn[3].d2  = d2w[63:0];

    cn[4]     = xa;
    cn[4].sep = dist_r;
    cn[4].gap = xa.rsum - dist_r;

    cn[5]     = c[4];
    cn[5].gux = c[4].gap * c[4].ux;
    cn[5].guy = c[4].gap * c[4].uy;

    // Push each disc away from the other
    soffx     = xb.dxneg ? (34'sd0 - $signed({3'b0, offx})) : $signed({3'b0, offx});
    soffy     = xb.dyneg ? (34'sd0 - $signed({3'b0, offy})) : $signed({3'b0, offy});
    cn[6]     = xb;
    cn[6].q1x = 34'(xb.p1x) + soffx;
    cn[6].q1y = 34'(xb.p1y) + soffy;
    cn[6].q2x = 34'(xb.p2x) - soffx;
    cn[6].q2y = 34'(xb.p2y) - soffy;

    nrx         = 35'(c[6].q2x) - 35'(c[6].q1x);
    nry         = 35'(c[6].q2y) - 35'(c[6].q1y);
    cn[7]       = c[6];
    cn[7].nxneg = nrx[34];
    cn[7].nyneg = nry[34];
    cn[7].nx    = nrx[34] ? 33'(-nrx) : 33'(nrx);
    cn[7].ny    = nry[34] ? 33'(-nry) : 33'(nry);

    // Normalize so the larger component lands in [2^32, 2^33)
    bigv = (c[7].nx > c[7].ny) ? c[7].nx : c[7].ny;
    nxv  = c[7].nx;
    nyv  = c[7].ny;
    for (int i = 0; i < 6; i++) begin
      if ((bigv >> (33 - (32 >> i))) == 33'd0) begin
        bigv = bigv << (32 >> i);
        nxv  = nxv << (32 >> i);
        nyv  = nyv << (32 >> i);
      end
    end
    cn[8]    = c[7];
    cn[8].nx = nxv;
    cn[8].ny = nyv;

    cn[9]      = c[8];
    cn[9].nsqx = c[8].nx * c[8].nx;
    cn[9].nsqy = c[8].ny * c[8].ny;

    cn[10]      = c[9];
    cn[10].len2 = 68'(c[9].nsqx) + 68'(c[9].nsqy);

    cn[11]     = xc;
    cn[11].len = (len_r == 34'd0) ? 34'd1 : len_r;

    cn[12]     = xd;
    cn[12].w2  = w2q;
    cn[12].nqx = xd.nxneg ? (30'sd0 - $signed({1'b0, nmx})) : $signed({1'b0, nmx});
    cn[12].nqy = xd.nyneg ? (30'sd0 - $signed({1'b0, nmy})) : $signed({1'b0, nmy});

    // Projections on normal and tangent (tangent = (-ny, nx))
    cn[13]      = c[12];
    cn[13].pa1x = c[12].v1x * c[12].nqx;
    cn[13].pa1y = c[12].v1y * c[12].nqy;
    cn[13].pa2x = c[12].v2x * c[12].nqx;
    cn[13].pa2y = c[12].v2y * c[12].nqy;
    cn[13].pb1x = c[12].v1x * (-c[12].nqy);
    cn[13].pb1y = c[12].v1y * c[12].nqx;
    cn[13].pb2x = c[12].v2x * (-c[12].nqy);
    cn[13].pb2y = c[12].v2y * c[12].nqx;

    sa1       = 63'(c[13].pa1x) + 63'(c[13].pa1y);
    sa2       = 63'(c[13].pa2x) + 63'(c[13].pa2y);
    sb1       = 63'(c[13].pb1x) + 63'(c[13].pb1y);
    sb2       = 63'(c[13].pb2x) + 63'(c[13].pb2y);
    cn[14]    = c[13];
    cn[14].a1 = 34'(sa1 >>> NORM_BITS);
    cn[14].a2 = 34'(sa2 >>> NORM_BITS);
    cn[14].b1 = 34'(sb1 >>> NORM_BITS);
    cn[14].b2 = 34'(sb2 >>> NORM_BITS);

    cn[15]     = c[14];
    cn[15].d21 = 35'(c[14].a2) - 35'(c[14].a1);
    cn[15].d12 = 35'(c[14].a1) - 35'(c[14].a2);

    // 1D elastic exchange along the normal
    w1        = 29'd268435456 - c[15].w2;
    cn[16]    = c[15];
    cn[16].e1 = $signed({1'b0, c[15].w2, 1'b0}) * c[15].d21;
    cn[16].e2 = $signed({1'b0, w1, 1'b0}) * c[15].d12;

    cn[17]    = c[16];
    cn[17].c1 = 37'(c[16].a1) + 37'(c[16].e1 >>> NORM_BITS);
    cn[17].c2 = 37'(c[16].a2) + 37'(c[16].e2 >>> NORM_BITS);

    cn[18]     = c[17];
    cn[18].t1x = (-c[17].nqy) * c[17].b1;
    cn[18].t1y = c[17].nqx * c[17].b1;
    cn[18].t2x = (-c[17].nqy) * c[17].b2;
    cn[18].t2y = c[17].nqx * c[17].b2;
    cn[18].n1x = c[17].nqx * c[17].c1;
    cn[18].n1y = c[17].nqy * c[17].c1;
    cn[18].n2x = c[17].nqx * c[17].c2;
    cn[18].n2y = c[17].nqy * c[17].c2;

    // Recombine and select; pass inputs through unless resolved
    f1x = 68'(c[18].t1x) + 68'(c[18].n1x);
    f1y = 68'(c[18].t1y) + 68'(c[18].n1y);
    f2x = 68'(c[18].t2x) + 68'(c[18].n2x);
    f2y = 68'(c[18].t2y) + 68'(c[18].n2y);
    ok  = c[18].ovl && !c[18].deg;
    res_next.collided   = ok;
    res_next.degenerate = c[18].deg;
    res_next.p1x = ok ? sat32(70'(c[18].q1x)) : c[18].p1x;
    res_next.p1y = ok ? sat32(70'(c[18].q1y)) : c[18].p1y;
    res_next.p2x = ok ? sat32(70'(c[18].q2x)) : c[18].p2x;
    res_next.p2y = ok ? sat32(70'(c[18].q2y)) : c[18].p2y;
    res_next.v1x = ok ? sat32(70'(f1x >>> NORM_BITS)) : c[18].v1x;
    res_next.v1y = ok ? sat32(70'(f1y >>> NORM_BITS)) : c[18].v1y;
    res_next.v2x = ok ? sat32(70'(f2x >>> NORM_BITS)) : c[18].v2x;
    res_next.v2y = ok ? sat32(70'(f2y >>> NORM_BITS)) : c[18].v2y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= vld_next;
      out_valid <= vld[18];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c   <= cn;
      res <= res_next;
    end
  end

  assign collided         = res.collided;
  assign degenerate       = res.degenerate;
  assign new_first_pos_x  = res.p1x;
  assign new_first_pos_y  = res.p1y;
  assign new_first_vel_x  = res.v1x;
  assign new_first_vel_y  = res.v1y;
  assign new_second_pos_x = res.p2x;
  assign new_second_pos_y = res.p2y;
  assign new_second_vel_x = res.v2x;
  assign new_second_vel_y = res.v2y;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dpec_pkg::*;

  localparam int LATENCY   = 145;
  localparam int NUM_RAND  = 750;
  localparam int MAX_CYCLES = 400000;
  localparam int NUM_DIR   = 16;

  typedef struct {
    logic signed [31:0] p1x, p1y, v1x, v1y;
    logic [30:0]        r1, m1;
    logic signed [31:0] p2x, p2y, v2x, v2y;
    logic [30:0]        r2, m2;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] first_pos_x = '0, first_pos_y = '0, first_vel_x = '0, first_vel_y = '0;
  logic [30:0]        first_radius = '0, first_mass = '0;
  logic signed [31:0] second_pos_x = '0, second_pos_y = '0;
  logic signed [31:0] second_vel_x = '0, second_vel_y = '0;
  logic [30:0]        second_radius = '0, second_mass = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic collided, degenerate;
  logic signed [31:0] new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y;
  logic signed [31:0] new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y;

  disc_pair_elastic_collision dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  res_t   resolved_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     stim_done = 1'b0;
  bit     hold_off = 1'b0;

  // Exact integer square root, floor.
  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint fshr(input longint x, input int s);
    return x >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic res_t resolve_pair(input pair_t p);
    res_t   r;
    longint dx, dy, q1x, q1y, q2x, q2y, nrx, nry, nqx, nqy, tx, ty;
    longint a1, a2, b1, b2, c1, c2, sx, sy;
    logic [63:0] ux, uy, msum, rsum, d, gap, offx, offy, nx, ny, big, len, w1, w2;
    logic [127:0] d2;
    r.collided = 1'b0; r.degenerate = 1'b0;
    r.p1x = p.p1x; r.p1y = p.p1y; r.v1x = p.v1x; r.v1y = p.v1y;
    r.p2x = p.p2x; r.p2y = p.p2y; r.v2x = p.v2x; r.v2y = p.v2y;
    dx = longint'(p.p1x) - longint'(p.p2x);
    dy = longint'(p.p1y) - longint'(p.p2y);
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    msum = 64'(p.m1) + 64'(p.m2);
    rsum = 64'(p.r1) + 64'(p.r2);
    if ((dx == 0 && dy == 0) || msum == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    d2 = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
    if (d2 > 128'(rsum) * 128'(rsum)) return r;
    d = isqrt(d2);
    gap = rsum - d;
    offx = (gap * ux) / (2 * d);
    offy = (gap * uy) / (2 * d);
    sx = dx < 0 ? -longint'(offx) : longint'(offx);
    sy = dy < 0 ? -longint'(offy) : longint'(offy);
    q1x = p.p1x + sx; q1y = p.p1y + sy;
    q2x = p.p2x - sx; q2y = p.p2y - sy;
    nrx = q2x - q1x; nry = q2y - q1y;
    nx = nrx < 0 ? -nrx : nrx;
    ny = nry < 0 ? -nry : nry;
    big = nx > ny ? nx : ny;
    while (big != 0 && (big << 1) < (64'd1 << 33)) begin
      big <<= 1; nx <<= 1; ny <<= 1;
    end
    len = isqrt(128'(nx) * 128'(nx) + 128'(ny) * 128'(ny));
    if (len == 0) len = 1;
    nqx = longint'((nx << NORM_BITS) / len);
    nqy = longint'((ny << NORM_BITS) / len);
    if (nrx < 0) nqx = -nqx;
    if (nry < 0) nqy = -nqy;
    tx = -nqy; ty = nqx;
    a1 = fshr(p.v1x * nqx + p.v1y * nqy, NORM_BITS);
    a2 = fshr(p.v2x * nqx + p.v2y * nqy, NORM_BITS);
    b1 = fshr(p.v1x * tx + p.v1y * ty, NORM_BITS);
    b2 = fshr(p.v2x * tx + p.v2y * ty, NORM_BITS);
    w2 = (64'(p.m2) << NORM_BITS) / msum;
    w1 = (64'd1 << NORM_BITS) - w2;
    c1 = a1 + fshr(2 * longint'(w2) * (a2 - a1), NORM_BITS);
    c2 = a2 + fshr(2 * longint'(w1) * (a1 - a2), NORM_BITS);
    r.collided = 1'b1;
    r.p1x = clamp32(q1x); r.p1y = clamp32(q1y);
    r.p2x = clamp32(q2x); r.p2y = clamp32(q2y);
    r.v1x = clamp32(fshr(tx * b1 + nqx * c1, NORM_BITS));
    r.v1y = clamp32(fshr(ty * b1 + nqy * c1, NORM_BITS));
    r.v2x = clamp32(fshr(tx * b2 + nqx * c2, NORM_BITS));
    r.v2y = clamp32(fshr(ty * b2 + nqy * c2, NORM_BITS));
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  // Random pair, mostly close enough to touch.
  function automatic pair_t rand_pair();
    pair_t p;
    int    k;
    k = $urandom_range(0, 99);
    p.v1x = rnd32() >>> $urandom_range(0, 31);
    p.v1y = rnd32() >>> $urandom_range(0, 31);
    p.v2x = rnd32() >>> $urandom_range(0, 31);
    p.v2y = rnd32() >>> $urandom_range(0, 31);
    p.m1 = 31'(rnd32() >> $urandom_range(1, 31));
    p.m2 = 31'(rnd32() >> $urandom_range(1, 31));
    if (k < 5) begin
      p.p1x = rnd32(); p.p1y = rnd32(); p.p2x = rnd32(); p.p2y = rnd32();
      p.r1 = 31'(rnd32()); p.r2 = 31'(rnd32());
      p.v1x = rnd32(); p.v2y = rnd32(); p.m1 = 31'(rnd32()); p.m2 = 31'(rnd32());
    end else begin
      p.p1x = rnd32() >>> $urandom_range(1, 8);
      p.p1y = rnd32() >>> $urandom_range(1, 8);
      p.r1 = 31'(rnd32() >> $urandom_range(2, 28));
      p.r2 = 31'(rnd32() >> $urandom_range(2, 28));
      p.p2x = p.p1x + ($signed(rnd32()) >>> $urandom_range(3, 30));
      p.p2y = p.p1y + ($signed(rnd32()) >>> $urandom_range(3, 30));
      if (k < 8) begin
        p.p2x = p.p1x; p.p2y = p.p1y;
      end else if (k < 11) begin
        p.m1 = '0; p.m2 = '0;
      end
    end
    return p;
  endfunction

  pair_t dir_pairs[NUM_DIR];
  bit    dir_known[NUM_DIR];
  res_t  dir_expect[NUM_DIR];

  initial begin
    pair_t z, p;
    z = '{default: '0};
    for (int i = 0; i < NUM_DIR; i++) begin
      dir_pairs[i] = z;
      dir_known[i] = 1'b0;
    end
    // coincident centres at zero
    dir_pairs[0].m1 = 31'h10000; dir_pairs[0].r1 = 31'h10000;
    // zero total mass, overlapping
    p = z; p.p1x = 32'sh10000; p.r1 = 31'h20000; p.v1x = 32'sh7fffffff;
    dir_pairs[1] = p;
    // far apart, pass through with extreme values
    p = z; p.p1x = 32'sh80000000; p.p1y = 32'sh80000000; p.p2x = 32'sh7fffffff;
    p.p2y = 32'sh7fffffff; p.v1x = 32'sh80000000; p.v2y = 32'sh7fffffff;
    p.m1 = 31'h7fffffff; p.m2 = 31'h7fffffff;
    dir_pairs[2] = p;
    // coincident at the extremes
    p = z; p.p1x = 32'sh7fffffff; p.p2x = 32'sh7fffffff; p.p1y = 32'sh80000000;
    p.p2y = 32'sh80000000; p.m2 = 31'h7fffffff; p.r1 = 31'h7fffffff;
    p.r2 = 31'h7fffffff; p.v1y = 32'sh80000000;
    dir_pairs[3] = p;
    for (int i = 0; i < 4; i++) begin
      dir_known[i] = 1'b1;
      dir_expect[i] = '{collided: 1'b0, degenerate: (i != 2), p1x: dir_pairs[i].p1x,
                        p1y: dir_pairs[i].p1y, v1x: dir_pairs[i].v1x,
                        v1y: dir_pairs[i].v1y, p2x: dir_pairs[i].p2x,
                        p2y: dir_pairs[i].p2y, v2x: dir_pairs[i].v2x,
                        v2y: dir_pairs[i].v2y};
    end
    // exactly touching, head on
    p = z; p.p2x = 32'sh20000; p.r1 = 31'h10000; p.r2 = 31'h10000;
    p.v1x = 32'sh10000; p.v2x = -32'sh10000; p.m1 = 31'h10000; p.m2 = 31'h10000;
    dir_pairs[4] = p;
    // deep overlap, unequal masses, diagonal
    p = z; p.p1x = 32'sh1000; p.p1y = -32'sh3000; p.r1 = 31'h40000; p.r2 = 31'h30000;
    p.v1x = 32'sh28000; p.v1y = -32'sh5000; p.v2x = -32'sh1234; p.v2y = 32'sh9999;
    p.m1 = 31'h1; p.m2 = 31'h7fffffff;
    dir_pairs[5] = p;
    // one mass zero
    p = dir_pairs[5]; p.m2 = '0; p.m1 = 31'h30000;
    dir_pairs[6] = p;
    // huge radii near the range edge, corrected centres saturate
    p = z; p.p1x = 32'sh7fff0000; p.p2x = 32'sh7ffe0000; p.p1y = 32'sh80000000;
    p.p2y = 32'sh80010000; p.r1 = 31'h7fffffff; p.r2 = 31'h7fffffff;
    p.v1x = 32'sh7fffffff; p.v1y = 32'sh80000000; p.v2x = 32'sh80000000;
    p.v2y = 32'sh7fffffff; p.m1 = 31'h7fffffff; p.m2 = 31'h1;
    dir_pairs[7] = p;
    // maximum separation with maximum radii
    p = dir_pairs[7]; p.p1x = 32'sh80000000; p.p2x = 32'sh7fffffff;
    p.p2y = 32'sh7fffffff;
    dir_pairs[8] = p;
    // just out of touch
    p = dir_pairs[4]; p.p2x = 32'sh20001;
    dir_pairs[9] = p;
    for (int i = 10; i < NUM_DIR; i++) dir_pairs[i] = rand_pair();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIR + NUM_RAND; i++) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      p = i < NUM_DIR ? dir_pairs[i] : rand_pair();
      first_pos_x <= p.p1x; first_pos_y <= p.p1y;
      first_vel_x <= p.v1x; first_vel_y <= p.v1y;
      first_radius <= p.r1; first_mass <= p.m1;
      second_pos_x <= p.p2x; second_pos_y <= p.p2y;
      second_vel_x <= p.v2x; second_vel_y <= p.v2y;
      second_radius <= p.r2; second_mass <= p.m2;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      if (i < NUM_DIR && dir_known[i]) resolved_q = {resolved_q, dir_expect[i]};
      else resolved_q = {resolved_q, resolve_pair(p)};
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps going.
  initial begin
    int g;
    @(negedge rst);
    repeat (200) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      g = hold_off ? 0 : gap_len();
      if (cycles > 2000 && cycles < 2400 && !hold_off) begin
        hold_off = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < 400; c++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{collided, degenerate, new_first_pos_x, new_first_pos_y, new_first_vel_x,
              new_first_vel_y, new_second_pos_x, new_second_pos_y, new_second_vel_x,
              new_second_vel_y};
      if (resolved_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = resolved_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    wait (stim_done && resolved_q.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    wait (cycles >= MAX_CYCLES);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
